// ----- design/ecb_pkg.sv -----
// Package for the edge coverage bitmap unit.
// Field widths, controller command/status structs. No dependencies.
package ecb_pkg;

   localparam int LINE_W    = 23;
   localparam int OPC_W     = 8;
   localparam int RD_IDX_W  = 16;
   localparam int CNT_W     = 8;
   localparam int OUT_IDX_W = 16;
   localparam int LOC_W     = LINE_W + OPC_W;
   localparam int PREV_W    = LOC_W - 1;

   localparam logic FUNC_TRACE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef struct packed {
      logic accept;
      logic clear;
      logic commit;
   } ecb_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ecb_status_type;

endpackage

// ----- design/ecb_datapath.sv -----
// Datapath: counter memory, previous-location register, index forming, result register.
// Depends on ecb_pkg; driven by ecb_ctrl through ecb_cmd_type.
module ecb_datapath #(
   parameter int MAP_ENTRIES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ecb_pkg::ecb_cmd_type              cmd,
   output ecb_pkg::ecb_status_type           status,
   input  logic                              req_func,
   input  logic [ecb_pkg::LINE_W-1:0]        req_line_number,
   input  logic [ecb_pkg::OPC_W-1:0]         req_opcode,
   input  logic [ecb_pkg::RD_IDX_W-1:0]      req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ecb_pkg::OUT_IDX_W-1:0]     rsp_entry_index,
   output logic [ecb_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                              rsp_updated
);
   import ecb_pkg::*;

   localparam int IDX_W = $clog2(MAP_ENTRIES);

   logic [CNT_W-1:0]     hit_mem [MAP_ENTRIES];
   logic [CNT_W-1:0]     rdata_ff;

   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [PREV_W-1:0]    prev_ff, prev_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 bump_ff, bump_in;
   logic                 zero_ff, zero_in;
   logic                 valid_ff, valid_in;
   logic [OUT_IDX_W-1:0] oidx_ff, oidx_in;
   logic [CNT_W-1:0]     ocnt_ff, ocnt_in;
   logic                 oupd_ff, oupd_in;

   logic [LOC_W-1:0]     loc;
   logic [LOC_W-1:0]     mix;
   logic [31:0]          rd_ext;
   logic [31:0]          idx_ext;
   logic [IDX_W-1:0]     rd_addr;
   logic [CNT_W-1:0]     sum;

   assign loc     = {req_line_number, req_opcode};
   assign mix     = loc ^ {1'b0, prev_ff};
   assign rd_ext  = {{(32-RD_IDX_W){1'b0}}, req_read_index};
   assign rd_addr = (req_func == FUNC_READ) ? rd_ext[IDX_W-1:0] : mix[IDX_W-1:0];
   assign idx_ext = {{(32-IDX_W){1'b0}}, idx_ff};
   assign sum     = rdata_ff + {{(CNT_W-1){1'b0}}, bump_ff};

   always_comb begin
      clr_in   = cmd.clear ? clr_ff + IDX_W'(1) : clr_ff;
      prev_in  = prev_ff;
      idx_in   = idx_ff;
      bump_in  = bump_ff;
      zero_in  = zero_ff;
      valid_in = valid_ff;
      oidx_in  = oidx_ff;
      ocnt_in  = ocnt_ff;
      oupd_in  = oupd_ff;
      if (cmd.accept) begin
         idx_in  = rd_addr;
         bump_in = (req_func == FUNC_TRACE) && (prev_ff != '0);
         zero_in = (req_func == FUNC_TRACE) && (prev_ff == '0);
         if (req_func == FUNC_TRACE) begin
            prev_in = loc[LOC_W-1:1];
         end
      end
      if (cmd.commit) begin
         valid_in = 1'b1;
         oidx_in  = zero_ff ? '0 : idx_ext[OUT_IDX_W-1:0];
         ocnt_in  = zero_ff ? '0 : sum;
         oupd_in  = bump_ff;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         prev_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         prev_ff  <= prev_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      bump_ff <= bump_in;
      zero_ff <= zero_in;
      oidx_ff <= oidx_in;
      ocnt_ff <= ocnt_in;
      oupd_ff <= oupd_in;
   end

   // single port: clear sweep or write-back, read on accept
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         hit_mem[clr_ff] <= '0;
      end else if (cmd.commit && bump_ff) begin
         hit_mem[idx_ff] <= sum;
      end
      if (cmd.accept) begin
         rdata_ff <= hit_mem[rd_addr];
      end
   end

   assign status.clear_last = (clr_ff == {IDX_W{1'b1}});
   assign status.out_free   = !valid_ff || rsp_ready;

   assign rsp_valid       = valid_ff;
   assign rsp_entry_index = oidx_ff;
   assign rsp_entry_count = ocnt_ff;
   assign rsp_updated     = oupd_ff;

endmodule

// ----- design/ecb_ctrl.sv -----
// Controller: clearing sweep after reset, accept, then commit of each beat.
// Depends on ecb_pkg.
module ecb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ecb_pkg::ecb_status_type status,
   output ecb_pkg::ecb_cmd_type    cmd
);
   import ecb_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/edge_coverage_bitmap_unit.sv -----
// Edge coverage bitmap unit: top level joining ecb_ctrl and ecb_datapath.
// Depends on ecb_pkg, ecb_ctrl, ecb_datapath.
//
// A trace beat (func 0) forms location = line << 8 | opcode; if the stored previous
// location is nonzero the counter at (location ^ previous) mod MAP_ENTRIES is
// incremented (wrapping at 8 bits) and returned, else the result is all zero; the
// previous location then becomes location >> 1. A read beat (func 1) returns the
// counter at read_index mod MAP_ENTRIES. MAP_ENTRIES must be a power of two.
// A beat reads the single-port counter memory, then commits; the commit waits
// while the output register is full and writes back counted trace beats only.
// Reset sweeps the memory to zero, one entry per cycle, with req_ready low; a
// finished result waits in the output register while the next beat is taken.
module edge_coverage_bitmap_unit #(
   parameter int MAP_ENTRIES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [ecb_pkg::LINE_W-1:0]    req_line_number,
   input  logic [ecb_pkg::OPC_W-1:0]     req_opcode,
   input  logic [ecb_pkg::RD_IDX_W-1:0]  req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ecb_pkg::OUT_IDX_W-1:0] rsp_entry_index,
   output logic [ecb_pkg::CNT_W-1:0]     rsp_entry_count,
   output logic                          rsp_updated
);
   import ecb_pkg::*;

   ecb_cmd_type    cmd;
   ecb_status_type status;

   ecb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecb_datapath #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_line_number (req_line_number),
      .req_opcode      (req_opcode),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_index (rsp_entry_index),
      .rsp_entry_count (rsp_entry_count),
      .rsp_updated     (rsp_updated)
   );

endmodule
